// ===== rtl/salc_pkg.sv =====
// shared types and constants of the set-associative lru cache lookup core
`timescale 1ns / 1ps
package salc_pkg;
  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int NUM_SETS     = 1 << MAX_SET_BITS;
  localparam int ADDR_W       = 64;
  localparam int CNT_W        = 32;
  localparam int RANK_W       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_W        = RANK_W;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] tag;
    logic [RANK_W-1:0] rank;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  typedef struct packed {
    logic accept;
    logic update;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } ctrl_sts_t;
endpackage

// ===== rtl/salc_if.sv =====
// item channel interfaces for address in and lookup result out
`timescale 1ns / 1ps
interface salc_in_if;
  import salc_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;
  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

interface salc_out_if;
  import salc_pkg::*;
  logic             valid;
  logic             ready;
  logic             was_hit;
  logic             was_evict;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] miss_total;
  logic [CNT_W-1:0] evict_total;
  modport source (output valid, output was_hit, output was_evict, output hit_total,
                  output miss_total, output evict_total, input ready);
  modport sink (input valid, input was_hit, input was_evict, input hit_total,
                input miss_total, input evict_total, output ready);
endinterface

// ===== rtl/salc_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/salc_ctrl.sv =====
// controller state machine for the lookup sequence
`timescale 1ns / 1ps
module salc_ctrl import salc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);
  state_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt     = st_r;
    in_ready   = 1'b0;
    cmd.update = 1'b0;
    case (st_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_LOOKUP: begin
        st_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!sts.out_busy) begin
          cmd.update = 1'b1;
          in_ready   = 1'b1;
          st_nxt     = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
    cmd.accept = in_valid && in_ready;
    if (cmd.accept) begin
      st_nxt = ST_LOOKUP;
    end
  end

  a_lookup_then_update: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_LOOKUP |=> st_r == ST_UPDATE) else $error("lookup not followed by update");
  a_no_accept_in_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> st_r != ST_LOOKUP) else $error("item accepted during lookup");
  a_update_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> !sts.out_busy && st_r == ST_UPDATE) else $error("update while blocked");
endmodule

// ===== rtl/salc_dp.sv =====
// datapath: address split, tag ram, way compare, lru update, counters, result register
`timescale 1ns / 1ps
module salc_dp import salc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [ADDR_W-1:0]     in_address,
  input  ctrl_cmd_t             cmd,
  output ctrl_sts_t             sts,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  out_was_hit,
  output logic                  out_was_evict,
  output logic [CNT_W-1:0]      out_hit_total,
  output logic [CNT_W-1:0]      out_miss_total,
  output logic [CNT_W-1:0]      out_evict_total
);
  localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int SUM_W  = 7;
  localparam int WCNT_W = 4;
  localparam int ORNK_W = RANK_W + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  logic [2:0]        set_bits_r;
  logic [5:0]        offset_bits_r;
  logic [3:0]        ways_cfg_r;
  logic [ADDR_W-1:0] tag_r;
  logic [SET_W-1:0]  set_r;
  logic [NUM_SETS-1:0] row_ok_r;
  logic [CNT_W-1:0]  hit_cnt_r, miss_cnt_r, evict_cnt_r;
  logic [CNT_W-1:0]  hit_cnt_nxt, miss_cnt_nxt, evict_cnt_nxt;
  logic              out_valid_r, hit_r, evict_r;

  logic [2:0]        s_eff;
  logic [SUM_W-1:0]  sum;
  logic [ADDR_W-1:0] tag_nxt, shifted;
  logic [SET_W-1:0]  set_nxt;
  logic [WCNT_W-1:0] ways;
  row_t              rd_row, ram_q, wr_row;
  logic [$bits(row_t)-1:0] ram_q_bits;
  logic              hit, evict;
  logic              found_hit, found_empty;
  logic [WAY_W-1:0]  hit_way, empty_way, victim, sel_way;
  logic [RANK_W-1:0] oldest;
  logic [ORNK_W-1:0] old_rank;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r    <= '0;
      offset_bits_r <= '0;
      ways_cfg_r    <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_INDEX_BITS: set_bits_r    <= cfg_data[2:0];
        CFG_OFFSET_BITS:    offset_bits_r <= cfg_data[5:0];
        CFG_WAYS_IN_USE:    ways_cfg_r    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    s_eff   = (set_bits_r > 3'(MAX_SET_BITS)) ? 3'(MAX_SET_BITS) : set_bits_r;
    sum     = SUM_W'(s_eff) + SUM_W'(offset_bits_r);
    tag_nxt = (sum >= SUM_W'(ADDR_W)) ? '0 : (in_address >> sum);
    shifted = in_address >> offset_bits_r;
    set_nxt = SET_W'(shifted) & SET_W'((SET_W+1)'(1) << s_eff) - SET_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tag_r <= tag_nxt;
      set_r <= set_nxt;
    end
  end

  salc_ram #(.WIDTH($bits(row_t)), .DEPTH(NUM_SETS)) u_ram (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (set_r),
    .wdata (wr_row),
    .raddr (set_r),
    .rdata (ram_q_bits)
  );

  assign ram_q  = row_t'(ram_q_bits);
  assign rd_row = row_ok_r[set_r] ? ram_q : '0;

  always_comb begin
    if (ways_cfg_r == '0) begin
      ways = 4'd1;
    end else if (ways_cfg_r > 4'(MAX_WAYS)) begin
      ways = 4'(MAX_WAYS);
    end else begin
      ways = ways_cfg_r;
    end
  end

  always_comb begin
    found_hit   = 1'b0;
    found_empty = 1'b0;
    hit_way     = '0;
    empty_way   = '0;
    victim      = '0;
    oldest      = rd_row[0].rank;
    for (int v = 0; v < MAX_WAYS; v++) begin
      if (WCNT_W'(v) < ways) begin
        if (rd_row[v].valid) begin
          if (!found_hit && rd_row[v].tag == tag_r) begin
            found_hit = 1'b1;
            hit_way   = WAY_W'(v);
          end
        end else if (!found_empty) begin
          found_empty = 1'b1;
          empty_way   = WAY_W'(v);
        end
        if (v > 0 && rd_row[v].rank > oldest) begin
          oldest = rd_row[v].rank;
          victim = WAY_W'(v);
        end
      end
    end
    hit   = found_hit;
    evict = !found_hit && !found_empty;
    if (found_hit) begin
      sel_way  = hit_way;
      old_rank = ORNK_W'(rd_row[hit_way].rank);
    end else if (found_empty) begin
      sel_way  = empty_way;
      old_rank = ORNK_W'(MAX_WAYS);
    end else begin
      sel_way  = victim;
      old_rank = ORNK_W'(oldest);
    end
    wr_row = rd_row;
    for (int v = 0; v < MAX_WAYS; v++) begin
      if (WCNT_W'(v) < ways && WAY_W'(v) != sel_way && rd_row[v].valid &&
          ORNK_W'(rd_row[v].rank) < old_rank && rd_row[v].rank < RANK_W'(MAX_WAYS-1)) begin
        wr_row[v].rank = rd_row[v].rank + RANK_W'(1);
      end
    end
    wr_row[sel_way].valid = 1'b1;
    wr_row[sel_way].tag   = tag_r;
    wr_row[sel_way].rank  = '0;
  end

  always_comb begin
    hit_cnt_nxt   = (hit && hit_cnt_r != CNT_MAX) ? hit_cnt_r + 1'b1 : hit_cnt_r;
    miss_cnt_nxt  = (!hit && miss_cnt_r != CNT_MAX) ? miss_cnt_r + 1'b1 : miss_cnt_r;
    evict_cnt_nxt = (evict && evict_cnt_r != CNT_MAX) ? evict_cnt_r + 1'b1 : evict_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_ok_r    <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.update) begin
        row_ok_r[set_r] <= 1'b1;
        hit_cnt_r       <= hit_cnt_nxt;
        miss_cnt_r      <= miss_cnt_nxt;
        evict_cnt_r     <= evict_cnt_nxt;
        out_valid_r     <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      hit_r   <= hit;
      evict_r <= evict;
    end
  end

  assign sts.out_busy   = out_valid_r && !out_ready;
  assign out_valid      = out_valid_r;
  assign out_was_hit    = hit_r;
  assign out_was_evict  = evict_r;
  assign out_hit_total  = hit_cnt_r;
  assign out_miss_total = miss_cnt_r;
  assign out_evict_total = evict_cnt_r;

  a_update_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> out_valid_r) else $error("result lost after update");
  a_hit_evict_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(hit_r && evict_r)) else $error("hit and evict together");
  a_evict_le_miss: assert property (@(posedge clk) disable iff (!rst_n)
    evict_cnt_r <= miss_cnt_r) else $error("evictions exceed misses");
endmodule

// ===== rtl/set_assoc_lru_cache_lookup_core.sv =====
// top level of the set-associative lru cache lookup core
// channel  dir  signals
// in_ch    in   valid, ready, address[63:0]
// out_ch   out  valid, ready, was_hit, was_evict, hit/miss/evict_total[31:0]
// cfg      in   cfg_we, cfg_index[1:0], cfg_data[5:0]
// each item passes a lookup state for the registered set read from the tag ram, then an update state for
// compare, lru update and write-back of the set row
// synchronous active low reset; set rows read as empty until first written (no sweep)
// a waiting result stalls the update cycle; a new item is taken as the result register frees
`timescale 1ns / 1ps
module set_assoc_lru_cache_lookup_core import salc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  salc_in_if.sink               in_ch,
  salc_out_if.source            out_ch
);
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  salc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  salc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_address      (in_ch.address),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_was_hit     (out_ch.was_hit),
    .out_was_evict   (out_ch.was_evict),
    .out_hit_total   (out_ch.hit_total),
    .out_miss_total  (out_ch.miss_total),
    .out_evict_total (out_ch.evict_total)
  );
endmodule

// ===== tb/tb_set_assoc_lru_cache_lookup_core.sv =====
// self-checking testbench of the set-associative lru cache lookup core
`timescale 1ns / 1ps
module tb_set_assoc_lru_cache_lookup_core;
  import salc_pkg::*;

  localparam int NUM_LINES  = NUM_SETS * MAX_WAYS;
  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD  = 400;
  localparam logic [CFG_IDX_W-1:0] CFG_BAD_INDEX = 2'd3;

  typedef struct packed {
    logic             hit;
    logic             evict;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] evicts;
  } lookup_res_t;

  typedef struct {
    logic [ADDR_W-1:0] address;
    bit                typed;
    lookup_res_t       res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  salc_in_if  in_bus ();
  salc_out_if out_bus ();

  set_assoc_lru_cache_lookup_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_bus),
    .out_ch   (out_bus)
  );

  always #4 clk = ~clk;

  // model state
  logic [2:0]        m_set_bits = 3'd0;
  logic [5:0]        m_offset   = 6'd0;
  logic [3:0]        m_ways     = 4'd1;
  bit                m_valid [NUM_LINES];
  logic [ADDR_W-1:0] m_tag   [NUM_LINES];
  logic [RANK_W-1:0] m_rank  [NUM_LINES];
  logic [CNT_W-1:0]  m_hits = '0, m_misses = '0, m_evicts = '0;

  lookup_res_t expected_lookups[$];
  int  errors = 0;
  int  mismatches = 0;
  bit  long_hold_req = 0;
  dir_row_t dir_rows[$];

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void age_set(int base, int ways, int w, int old_rank);
    for (int v = 0; v < ways; v++) begin
      if (v != w && m_valid[base+v] && m_rank[base+v] < old_rank &&
          m_rank[base+v] < MAX_WAYS - 1)
        m_rank[base+v] = m_rank[base+v] + 1'b1;
    end
    m_rank[base+w] = '0;
  endfunction

  function automatic lookup_res_t predict_lookup(logic [ADDR_W-1:0] addr);
    int s, b, ways, sum, base, hit_way, empty_way, victim, oldest;
    logic [ADDR_W-1:0] tag;
    int set;
    lookup_res_t r;
    s = (m_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : m_set_bits;
    b = m_offset;
    ways = m_ways;
    if (ways < 1) ways = 1;
    if (ways > MAX_WAYS) ways = MAX_WAYS;
    sum = s + b;
    tag = (sum >= ADDR_W) ? '0 : (addr >> sum);
    set = int'((addr >> b) & ((64'd1 << s) - 1));
    base = set * MAX_WAYS;
    hit_way = -1;
    empty_way = -1;
    r = '0;
    for (int w = 0; w < ways; w++) begin
      if (m_valid[base+w]) begin
        if (hit_way < 0 && m_tag[base+w] == tag) hit_way = w;
      end else if (empty_way < 0) begin
        empty_way = w;
      end
    end
    if (hit_way >= 0) begin
      r.hit = 1'b1;
      m_hits = sat_inc(m_hits);
      age_set(base, ways, hit_way, m_rank[base+hit_way]);
    end else begin
      m_misses = sat_inc(m_misses);
      if (empty_way >= 0) begin
        m_valid[base+empty_way] = 1;
        m_tag[base+empty_way] = tag;
        age_set(base, ways, empty_way, MAX_WAYS);
      end else begin
        victim = 0;
        oldest = m_rank[base];
        for (int w = 1; w < ways; w++) begin
          if (m_rank[base+w] > oldest) begin
            oldest = m_rank[base+w];
            victim = w;
          end
        end
        r.evict = 1'b1;
        m_evicts = sat_inc(m_evicts);
        m_tag[base+victim] = tag;
        age_set(base, ways, victim, oldest);
      end
    end
    r.hits = m_hits;
    r.misses = m_misses;
    r.evicts = m_evicts;
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_SET_INDEX_BITS) m_set_bits = val[2:0];
    else if (idx == CFG_OFFSET_BITS) m_offset = val[5:0];
    else if (idx == CFG_WAYS_IN_USE) m_ways = val[3:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    wait (expected_lookups.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_item(logic [ADDR_W-1:0] addr, int gap, bit typed, lookup_res_t typed_res);
    lookup_res_t r;
    repeat (gap) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk);
    in_bus.valid <= 1'b1;
    in_bus.address <= addr;
    do @(posedge clk); while (!in_bus.ready);
    r = predict_lookup(addr);
    expected_lookups.push_back(typed ? typed_res : r);
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_bus.valid <= 1'b0;
  endtask

  function automatic void add_row(logic [ADDR_W-1:0] a, bit typed, lookup_res_t r);
    dir_row_t d;
    d.address = a;
    d.typed = typed;
    d.res = r;
    dir_rows.push_back(d);
  endfunction

  // receiver
  initial begin
    int cyc;
    int mode;
    int hold;
    cyc = 0;
    mode = 0;
    hold = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (long_hold_req) begin
        long_hold_req = 0;
        hold = LONG_HOLD;
      end
      if (cyc % 64 == 0) mode = $urandom_range(0, 2);
      if (hold > 0) begin
        hold--;
        out_bus.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_bus.ready <= 1'b1;
          1: out_bus.ready <= $urandom_range(0, 1);
          default: out_bus.ready <= (cyc % 4 == 0);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    lookup_res_t got, exp_r;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = {out_bus.was_hit, out_bus.was_evict, out_bus.hit_total,
             out_bus.miss_total, out_bus.evict_total};
      if (expected_lookups.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("unexpected item: %p", got);
        mismatches++;
      end else begin
        exp_r = expected_lookups.pop_front();
        if (got !== exp_r) begin
          errors++;
          if (mismatches < 10)
            $display("mismatch: exp hit=%0b evict=%0b h=%0d m=%0d e=%0d got hit=%0b evict=%0b h=%0d m=%0d e=%0d",
                     exp_r.hit, exp_r.evict, exp_r.hits, exp_r.misses, exp_r.evicts,
                     got.hit, got.evict, got.hits, got.misses, got.evicts);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) idle = 0;
      else if (in_bus.valid || expected_lookups.size() > 0) idle++;
      else idle = 0;
      if (idle >= IDLE_LIMIT) begin
        $display("set_assoc_lru_cache_lookup_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [ADDR_W-1:0] tag_pool[12];
    logic [ADDR_W-1:0] a, t;
    int s, b, sum, burst, gap;
    lookup_res_t none;
    none = '0;
    in_bus.valid = 1'b0;
    in_bus.address = '0;
    for (int i = 0; i < NUM_LINES; i++) begin
      m_valid[i] = 0;
      m_tag[i] = '0;
      m_rank[i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // one set, one way after reset: tag is the whole address
    add_row(64'h0, 1, '{1'b0, 1'b0, 32'd0, 32'd1, 32'd0});
    add_row(64'h0, 1, '{1'b1, 1'b0, 32'd1, 32'd1, 32'd0});
    add_row('1,    1, '{1'b0, 1'b1, 32'd1, 32'd2, 32'd1});
    add_row('1,    1, '{1'b1, 1'b0, 32'd2, 32'd2, 32'd1});
    add_row(64'h0, 1, '{1'b0, 1'b1, 32'd2, 32'd3, 32'd2});
    add_row(64'h8000_0000_0000_0000, 0, none);
    add_row(64'h0000_0000_0000_0001, 0, none);
    foreach (dir_rows[i]) send_item(dir_rows[i].address, 0, dir_rows[i].typed, dir_rows[i].res);
    end_burst();
    wait_drained();

    // wide split, clamped set bits, zero ways, ignored bad index
    write_reg(CFG_SET_INDEX_BITS, 6'd7);
    write_reg(CFG_OFFSET_BITS, 6'd63);
    write_reg(CFG_WAYS_IN_USE, 6'd0);
    write_reg(CFG_BAD_INDEX, 6'h3f);
    send_item('1, 0, 0, none);
    send_item(64'h7fff_ffff_ffff_ffff, 0, 0, none);
    send_item(64'h8000_0000_0000_0000, 1, 0, none);
    end_burst();
    wait_drained();

    // full associativity, then shrink and grow for ties and stale matches
    write_reg(CFG_SET_INDEX_BITS, 6'd0);
    write_reg(CFG_OFFSET_BITS, 6'd0);
    write_reg(CFG_WAYS_IN_USE, 6'd15);
    for (int i = 0; i < 10; i++) send_item(64'(i % 9), 0, 0, none);
    end_burst();
    wait_drained();
    write_reg(CFG_WAYS_IN_USE, 6'd3);
    send_item(64'd20, 0, 0, none);
    send_item(64'd1, 0, 0, none);
    end_burst();
    wait_drained();
    write_reg(CFG_WAYS_IN_USE, 6'd8);
    send_item(64'd20, 0, 0, none);
    send_item(64'd21, 0, 0, none);
    end_burst();
    wait_drained();

    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin s = 6; b = 0; write_reg(CFG_WAYS_IN_USE, 6'd8); end
        1: begin s = 0; b = 32; write_reg(CFG_WAYS_IN_USE, 6'd1); end
        2: begin s = 7; b = 58; write_reg(CFG_WAYS_IN_USE, 6'd9); end
        default: begin
          s = $urandom_range(0, 7);
          b = $urandom_range(0, 63);
          write_reg(CFG_WAYS_IN_USE, 6'($urandom_range(0, 15)));
        end
      endcase
      write_reg(CFG_SET_INDEX_BITS, 6'(s));
      write_reg(CFG_OFFSET_BITS, 6'(b));
      if (s > MAX_SET_BITS) s = MAX_SET_BITS;
      sum = s + b;
      foreach (tag_pool[i])
        tag_pool[i] = (i < 6) ? 64'(i) : {$urandom, $urandom};
      if (ph == 3) long_hold_req = 1;
      for (int n = 0; n < 95; ) begin
        burst = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        for (int k = 0; k < burst; k++, n++) begin
          if ($urandom_range(0, 6) == 0) begin
            a = {$urandom, $urandom};
          end else begin
            t = tag_pool[$urandom_range(0, 11)];
            a = {$urandom, $urandom} & ((64'd1 << b) - 1);
            a |= (64'($urandom_range(0, 63)) & ((64'd1 << s) - 1)) << b;
            if (sum < ADDR_W) a |= t << sum;
          end
          send_item(a, (k == 0) ? gap : 0, 0, none);
        end
      end
      end_burst();
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && expected_lookups.size() == 0) begin
      $display("set_assoc_lru_cache_lookup_core verification clean");
    end else begin
      $display("set_assoc_lru_cache_lookup_core verification failed");
    end
    $finish;
  end
endmodule
